// ===== src/assert_macros.svh =====
// assertion macros for the rtl file that checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define KMP_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("kmp invariant violated");

// antecedent in this cycle implies consequent in the next one
`define KMP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmp sequencing violated");

`endif

// ===== src/kmp_pkg.sv =====
// shared constants and op codes for the kmp stream matcher
`default_nettype none

package kmp_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int LEN_W       = IDX_W + 1;
  localparam int POS_W       = 32;
  localparam int OP_W        = 2;
  localparam int BYTE_W      = 8;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_PAT   = 2'd1;
  localparam logic [OP_W-1:0] OP_TEXT  = 2'd2;
  localparam logic [OP_W-1:0] OP_END   = 2'd3;

endpackage

`default_nettype wire

// ===== src/kmp_in_if.sv =====
// input channel: op code and data byte with valid/ready
`default_nettype none

interface kmp_in_if import kmp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== src/kmp_out_if.sv =====
// result channel: match report and flags with valid/ready
`default_nettype none

interface kmp_out_if import kmp_pkg::*;;
  logic             valid;
  logic             ready;
  logic             match_found;
  logic [POS_W-1:0] match_start;
  logic             none_found;
  logic             pattern_overflow;

  modport source (output valid, output match_found, output match_start,
                  output none_found, output pattern_overflow, input ready);
  modport sink   (input valid, input match_found, input match_start,
                  input none_found, input pattern_overflow, output ready);
endinterface

`default_nettype wire

// ===== src/kmp_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none

module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/kmp_stream_matcher.sv =====
// kmp stream matcher: online failure table build and streaming text search
// flow: a transfer in is registered, then compared in S_CMP, again for each failure-table
//   fallback step; a text byte that completes a match also passes S_TAIL, and S_OUT moves
//   the result out once the output is free. Items are taken only in S_IDLE or S_OUT, so a new
//   item waits for the last; the compare loop is bound by the single read port of each ram
// reset: synchronous active-low clears lengths, indices, position and flags; rams keep contents
`default_nettype none
`include "assert_macros.svh"

module kmp_stream_matcher import kmp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  kmp_in_if.sink    in_ch,
  kmp_out_if.source out_ch
);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_TAIL, S_OUT} state_t;

  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  length_r, length_nxt;
  logic [IDX_W-1:0]  build_prefix_r, build_prefix_nxt;
  logic [LEN_W-1:0]  match_index_r, match_index_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              any_r, any_nxt;
  logic              ovf_r, ovf_nxt;

  logic [OP_W-1:0]   op_r, op_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;

  logic              res_found_r, res_found_nxt;
  logic [POS_W-1:0]  res_start_r, res_start_nxt;
  logic              res_none_r, res_none_nxt;
  logic              res_ovf_r, res_ovf_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [POS_W-1:0]  out_start_r, out_start_nxt;
  logic              out_none_r, out_none_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              pat_we, fail_we;
  logic [IDX_W-1:0]  wr_addr;
  logic [BYTE_W-1:0] pat_rdata;
  logic [IDX_W-1:0]  fail_wdata, fail_rdata;
  logic [IDX_W-1:0]  pat_raddr, fail_raddr;
  logic [IDX_W-1:0]  rd_k;
  logic [LEN_W-1:0]  len_m1;
  logic [LEN_W-1:0]  step;
  logic              hit, fallback, out_free, in_fire, in_rdy;

  kmp_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_PATTERN)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (wr_addr),
    .wdata (byte_r),
    .raddr (pat_raddr),
    .rdata (pat_rdata)
  );

  kmp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PATTERN)) u_fail_ram (
    .clk   (clk),
    .we    (fail_we),
    .waddr (wr_addr),
    .wdata (fail_wdata),
    .raddr (fail_raddr),
    .rdata (fail_rdata)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_rdy   = (state_r == S_IDLE) || ((state_r == S_OUT) && out_free);
  assign in_fire  = in_ch.valid && in_rdy;
  assign wr_addr  = length_r[IDX_W-1:0];
  assign len_m1   = length_r - LEN_W'(1);
  assign rd_k     = (in_ch.op == OP_PAT) ? build_prefix_r : match_index_r[IDX_W-1:0];
  assign hit      = (pat_rdata == byte_r);
  assign step     = hit ? ({1'b0, k_r} + LEN_W'(1)) : '0;
  assign fallback = !hit && (k_r != '0);

  assign in_ch.ready             = in_rdy;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.match_found      = out_found_r;
  assign out_ch.match_start      = out_start_r;
  assign out_ch.none_found       = out_none_r;
  assign out_ch.pattern_overflow = out_ovf_r;

  always_comb begin
    state_nxt        = state_r;
    length_nxt       = length_r;
    build_prefix_nxt = build_prefix_r;
    match_index_nxt  = match_index_r;
    pos_nxt          = pos_r;
    any_nxt          = any_r;
    ovf_nxt          = ovf_r;
    op_nxt           = op_r;
    byte_nxt         = byte_r;
    k_nxt            = k_r;
    res_found_nxt    = res_found_r;
    res_start_nxt    = res_start_r;
    res_none_nxt     = res_none_r;
    res_ovf_nxt      = res_ovf_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_found_nxt    = out_found_r;
    out_start_nxt    = out_start_r;
    out_none_nxt     = out_none_r;
    out_ovf_nxt      = out_ovf_r;
    pat_we           = 1'b0;
    fail_we          = 1'b0;
    fail_wdata       = '0;
    pat_raddr        = rd_k;
    fail_raddr       = rd_k - IDX_W'(1);

    case (state_r)
      S_IDLE, S_OUT: begin
        if ((state_r == S_OUT) && out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_start_nxt = res_start_r;
          out_none_nxt  = res_none_r;
          out_ovf_nxt   = res_ovf_r;
          state_nxt     = S_IDLE;
        end
        if (in_fire) begin
          op_nxt    = in_ch.op;
          byte_nxt  = in_ch.data_byte;
          k_nxt     = rd_k;
          state_nxt = S_CMP;
        end
      end

      S_CMP: begin
        state_nxt     = S_OUT;
        res_found_nxt = 1'b0;
        res_start_nxt = '0;
        res_none_nxt  = 1'b0;
        res_ovf_nxt   = ovf_r;
        case (op_r)
          OP_CLEAR: begin
            length_nxt       = '0;
            build_prefix_nxt = '0;
            match_index_nxt  = '0;
            pos_nxt          = '0;
            any_nxt          = 1'b0;
            ovf_nxt          = 1'b0;
            res_ovf_nxt      = 1'b0;
          end
          OP_PAT: begin
            if (length_r == LEN_W'(MAX_PATTERN)) begin
              ovf_nxt     = 1'b1;
              res_ovf_nxt = 1'b1;
            end else if (length_r == '0) begin
              pat_we           = 1'b1;
              fail_we          = 1'b1;
              build_prefix_nxt = '0;
              length_nxt       = LEN_W'(1);
            end else if (fallback) begin
              // follow the failure link and compare again next cycle
              k_nxt      = fail_rdata;
              pat_raddr  = fail_rdata;
              fail_raddr = fail_rdata - IDX_W'(1);
              state_nxt  = S_CMP;
            end else begin
              pat_we           = 1'b1;
              fail_we          = 1'b1;
              fail_wdata       = step[IDX_W-1:0];
              build_prefix_nxt = step[IDX_W-1:0];
              length_nxt       = length_r + LEN_W'(1);
            end
          end
          OP_TEXT: begin
            if (length_r == '0) begin
              pos_nxt = pos_r + POS_W'(1);
            end else if (fallback) begin
              k_nxt      = fail_rdata;
              pat_raddr  = fail_rdata;
              fail_raddr = fail_rdata - IDX_W'(1);
              state_nxt  = S_CMP;
            end else if (step == length_r) begin
              // full match: fetch the last failure entry to keep overlaps
              res_found_nxt = 1'b1;
              res_start_nxt = pos_r - POS_W'(length_r) + POS_W'(1);
              any_nxt       = 1'b1;
              pos_nxt       = pos_r + POS_W'(1);
              fail_raddr    = len_m1[IDX_W-1:0];
              state_nxt     = S_TAIL;
            end else begin
              match_index_nxt = step;
              pos_nxt         = pos_r + POS_W'(1);
            end
          end
          default: begin
            res_none_nxt    = !any_r;
            pos_nxt         = '0;
            match_index_nxt = '0;
            any_nxt         = 1'b0;
          end
        endcase
      end

      S_TAIL: begin
        match_index_nxt = {1'b0, fail_rdata};
        state_nxt       = S_OUT;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      length_r       <= '0;
      build_prefix_r <= '0;
      match_index_r  <= '0;
      pos_r          <= '0;
      any_r          <= 1'b0;
      ovf_r          <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      length_r       <= length_nxt;
      build_prefix_r <= build_prefix_nxt;
      match_index_r  <= match_index_nxt;
      pos_r          <= pos_nxt;
      any_r          <= any_nxt;
      ovf_r          <= ovf_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    byte_r      <= byte_nxt;
    k_r         <= k_nxt;
    res_found_r <= res_found_nxt;
    res_start_r <= res_start_nxt;
    res_none_r  <= res_none_nxt;
    res_ovf_r   <= res_ovf_nxt;
    out_found_r <= out_found_nxt;
    out_start_r <= out_start_nxt;
    out_none_r  <= out_none_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  `KMP_ASSERT_ALWAYS(a_len_bound, length_r <= LEN_W'(MAX_PATTERN))
  `KMP_ASSERT_ALWAYS(a_prefix_below_len, (length_r == '0) || ({1'b0, build_prefix_r} < length_r))
  `KMP_ASSERT_ALWAYS(a_index_below_len, (match_index_r == '0) || (match_index_r < length_r))
  `KMP_ASSERT_NEXT(a_accept_to_cmp, in_ch.valid && in_rdy, state_r == S_CMP)

endmodule

`default_nettype wire

// ===== tb/kmp_stream_matcher_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the kmp stream matcher: directed table, then random sessions
module kmp_stream_matcher_tb;
  import kmp_pkg::*;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] start;
    logic             none;
    logic             ovf;
  } report_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] b;
    bit                typed;
    report_t           want;
  } dir_row_t;

  localparam report_t RPT_IDLE = '{found: 1'b0, start: '0, none: 1'b0, ovf: 1'b0};
  localparam report_t RPT_NONE = '{found: 1'b0, start: '0, none: 1'b1, ovf: 1'b0};
  localparam int N_DIR       = 24;
  localparam int ITEM_TARGET = 1050;
  localparam int CALM_FROM   = 950;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 150;
  localparam int TAIL_CYCLES = 100;

  logic clk;
  logic rst_n;

  kmp_in_if  in_ch();
  kmp_out_if out_ch();

  kmp_stream_matcher dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // shadow copy of the matcher state
  logic [BYTE_W-1:0] pat_mem [MAX_PATTERN];
  int unsigned       fail_tbl [MAX_PATTERN];
  int unsigned       pat_len;
  int unsigned       build_k;
  int unsigned       cur_idx;
  logic [POS_W-1:0]  txt_pos;
  bit                seen_match;
  bit                seen_ovf;

  report_t     pending_reports [$];
  int unsigned items_sent;
  int unsigned reports_seen;
  int unsigned mismatches;
  bit          calm;

  // typed rows: empty pattern, fresh end of text, clears, first pattern bytes; the rest go through the predictor
  dir_row_t dir_rows [N_DIR] = '{
    '{OP_END,   8'hff, 1'b1, RPT_NONE},
    '{OP_TEXT,  8'h00, 1'b1, RPT_IDLE},
    '{OP_TEXT,  8'hff, 1'b1, RPT_IDLE},
    '{OP_END,   8'h00, 1'b1, RPT_NONE},
    '{OP_PAT,   8'hff, 1'b1, RPT_IDLE},
    '{OP_PAT,   8'h00, 1'b1, RPT_IDLE},
    '{OP_TEXT,  8'hff, 1'b0, RPT_IDLE},
    '{OP_TEXT,  8'h00, 1'b0, RPT_IDLE},
    '{OP_TEXT,  8'hff, 1'b0, RPT_IDLE},
    '{OP_TEXT,  8'h00, 1'b0, RPT_IDLE},
    '{OP_END,   8'h55, 1'b0, RPT_IDLE},
    '{OP_CLEAR, 8'hff, 1'b1, RPT_IDLE},
    '{OP_PAT,   8'h61, 1'b1, RPT_IDLE},
    '{OP_PAT,   8'h61, 1'b1, RPT_IDLE},
    '{OP_TEXT,  8'h61, 1'b0, RPT_IDLE},
    '{OP_TEXT,  8'h61, 1'b0, RPT_IDLE},
    '{OP_TEXT,  8'h61, 1'b0, RPT_IDLE},
    '{OP_TEXT,  8'h61, 1'b0, RPT_IDLE},
    '{OP_PAT,   8'h62, 1'b0, RPT_IDLE},
    '{OP_TEXT,  8'h61, 1'b0, RPT_IDLE},
    '{OP_TEXT,  8'h62, 1'b0, RPT_IDLE},
    '{OP_END,   8'haa, 1'b0, RPT_IDLE},
    '{OP_END,   8'h00, 1'b1, RPT_NONE},
    '{OP_CLEAR, 8'h00, 1'b1, RPT_IDLE}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // fall back through the failure table until the next byte extends the border
  function automatic int unsigned extend_border(int unsigned k, logic [BYTE_W-1:0] b);
    while (k > 0 && pat_mem[k] != b)
      k = fail_tbl[k - 1];
    if (pat_mem[k] == b)
      k++;
    return k;
  endfunction

  function automatic report_t predict_report(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b);
    report_t     r;
    int unsigned j;
    r = RPT_IDLE;
    case (op)
      OP_CLEAR: begin
        pat_len    = 0;
        build_k    = 0;
        seen_ovf   = 1'b0;
        cur_idx    = 0;
        txt_pos    = '0;
        seen_match = 1'b0;
      end
      OP_PAT: begin
        if (pat_len >= MAX_PATTERN) begin
          seen_ovf = 1'b1;
        end else begin
          pat_mem[pat_len] = b;
          if (pat_len == 0) begin
            fail_tbl[0] = 0;
            build_k     = 0;
          end else begin
            build_k           = extend_border(build_k, b);
            fail_tbl[pat_len] = build_k;
          end
          pat_len++;
        end
      end
      OP_TEXT: begin
        if (pat_len > 0) begin
          j = extend_border(cur_idx, b);
          if (j >= pat_len) begin
            r.found    = 1'b1;
            r.start    = txt_pos - pat_len + 1;
            seen_match = 1'b1;
            j          = fail_tbl[pat_len - 1];
          end
          cur_idx = j;
        end
        txt_pos = txt_pos + 1'b1;
      end
      default: begin
        // end of text
        r.none     = !seen_match;
        cur_idx    = 0;
        txt_pos    = '0;
        seen_match = 1'b0;
      end
    endcase
    r.ovf = seen_ovf;
    return r;
  endfunction

  task automatic transfer_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b,
                               input bit typed = 1'b0, input report_t given = RPT_IDLE);
    report_t rpt;
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    rpt = predict_report(op, b);
    pending_reports = {pending_reports, (typed ? given : rpt)};
    items_sent++;
    if (items_sent >= CALM_FROM)
      calm = 1'b1;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain_pending();
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // mostly a two-letter alphabet so that matches and partial matches are common
  function automatic logic [BYTE_W-1:0] pick_byte(logic [BYTE_W-1:0] base);
    if ($urandom_range(0, 9) == 0)
      return BYTE_W'($urandom);
    return base + BYTE_W'($urandom_range(0, 1));
  endfunction

  task automatic run_session(input bit go_long);
    logic [BYTE_W-1:0] base;
    logic [BYTE_W-1:0] pat_bytes [$];
    int unsigned       plen;
    int unsigned       tlen;
    int unsigned       n;
    base = BYTE_W'($urandom);
    if (go_long || $urandom_range(0, 4) != 0)
      transfer_item(OP_CLEAR, BYTE_W'($urandom));
    if (go_long)
      plen = $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 6);
    else if ($urandom_range(0, 19) == 0)
      plen = $urandom_range(20, MAX_PATTERN);
    else
      plen = $urandom_range(1, 6);
    repeat (plen) begin
      pat_bytes = {pat_bytes, pick_byte(base)};
      transfer_item(OP_PAT, pat_bytes[$]);
    end
    tlen = $urandom_range(8, 40);
    n = 0;
    while (n < tlen) begin
      if ($urandom_range(0, 3) == 0) begin
        foreach (pat_bytes[i])
          transfer_item(OP_TEXT, pat_bytes[i]);
        n += pat_bytes.size();
      end else if ($urandom_range(0, 29) == 0) begin
        // pattern grows while text is in progress
        pat_bytes = {pat_bytes, pick_byte(base)};
        transfer_item(OP_PAT, pat_bytes[$]);
      end else begin
        transfer_item(OP_TEXT, pick_byte(base));
        n++;
      end
    end
    if ($urandom_range(0, 9) != 0)
      transfer_item(OP_END, BYTE_W'($urandom));
  endtask

  task automatic check_report();
    report_t got;
    report_t want;
    bit      bad;
    got.found = out_ch.match_found;
    got.start = out_ch.match_start;
    got.none  = out_ch.none_found;
    got.ovf   = out_ch.pattern_overflow;
    reports_seen++;
    if (pending_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result %0d: found/start/none/ovf %b/%h/%b/%b",
                 reports_seen, got.found, got.start, got.none, got.ovf);
      return;
    end
    want = pending_reports.pop_front();
    bad = (got.found !== want.found) || (got.start !== want.start) ||
          (got.none !== want.none) || (got.ovf !== want.ovf);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d found/start/none/ovf: exp %b/%h/%b/%b got %b/%h/%b/%b",
                 reports_seen, want.found, want.start, want.none, want.ovf,
                 got.found, got.start, got.none, got.ovf);
    end
  endtask

  // result side: random stalls plus one long hold-off that backs up the input
  initial begin
    int unsigned stall_left;
    bit          held;
    stall_left   = 0;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        check_report();
      if (!held && reports_seen >= HOLD_AT) begin
        held       = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned sessions;
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_CLEAR;
    in_ch.data_byte = '0;
    rst_n           = 1'b0;
    foreach (pat_mem[i]) begin
      pat_mem[i]  = '0;
      fail_tbl[i] = 0;
    end
    pat_len      = 0;
    build_k      = 0;
    cur_idx      = 0;
    txt_pos      = '0;
    seen_match   = 1'b0;
    seen_ovf     = 1'b0;
    items_sent   = 0;
    reports_seen = 0;
    mismatches   = 0;
    calm         = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      transfer_item(dir_rows[i].op, dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);
    drain_pending();

    // second session overfills the pattern store
    sessions = 0;
    while (items_sent < ITEM_TARGET) begin
      run_session(sessions == 1);
      repeat ($urandom_range(0, 2))
        transfer_item(OP_W'($urandom_range(0, 3)), BYTE_W'($urandom));
      sessions++;
      if (sessions == 12)
        drain_pending();
    end

    drain_pending();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("kmp_stream_matcher_tb passed");
    else
      $display("kmp_stream_matcher_tb failed");
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("kmp_stream_matcher_tb failed");
    $finish;
  end

endmodule
